[rtl/front_to_back_ray_compositor_assert.svh]
// assertion macros for the compositor port checker
`ifndef FRONT_TO_BACK_RAY_COMPOSITOR_ASSERT_SVH
`define FRONT_TO_BACK_RAY_COMPOSITOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FTBRC_ASSERT_SAME(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FTBRC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

[rtl/ftbrc_pkg.sv]
// shared types and constants of the ray compositor
`timescale 1ns / 1ps
`default_nettype none
package ftbrc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PIXEL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ONLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OPA    = 2'd2;

  // reset values, Q0.16
  localparam logic [SAMPLE_W-1:0] TERM_LEVEL_RESET = 16'd63570;
  localparam logic [SAMPLE_W-1:0] MIN_OPA_RESET    = 16'd1;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input word
    logic calc_w;    // compute sample weight
    logic acc_upd;   // add weighted terms to accumulators
    logic emit;      // load pixel into output register, clear accumulators
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // captured word ends the ray
    logic out_free;  // output register can take a pixel this cycle
  } sts_t;

endpackage
`default_nettype wire

[rtl/ftbrc_ctrl.sv]
// sequencing controller of the ray compositor
`timescale 1ns / 1ps
`default_nettype none
module ftbrc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  ftbrc_pkg::sts_t   sts,
  output ftbrc_pkg::cmd_t   cmd
);
  import ftbrc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WGT  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_WGT;
        end
      end
      ST_WGT: begin
        cmd.calc_w = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_upd = 1'b1;
        state_next  = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold here while the previous pixel is still unclaimed
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/ftbrc_dp.sv]
// compositing datapath: weight and colour multipliers, accumulators, output register
`timescale 1ns / 1ps
`default_nettype none
module ftbrc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  ftbrc_pkg::cmd_t                      cmd,
  output ftbrc_pkg::sts_t                      sts,
  input  wire [4*ftbrc_pkg::SAMPLE_W-1:0]      s_tdata,
  input  wire [0:0]                            s_tuser,
  input  wire                                  s_tlast,
  input  wire                                  cfg_we,
  input  wire [ftbrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ftbrc_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [4*ftbrc_pkg::PIXEL_W-1:0]      m_tdata
);
  import ftbrc_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [F:0]     ONE   = {1'b1, {F{1'b0}}};
  localparam logic [2*F:0]   HALF  = {{(F+1){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [F+8:0]   HALF9 = {{9{1'b0}}, 1'b1, {(F-1){1'b0}}};

  // q0.16 to F fraction bits
  function automatic logic [F-1:0] to_fx(input logic [SAMPLE_W-1:0] v);
    logic [F+SAMPLE_W-1:0] t;
    t = {{F{1'b0}}, v} << F;
    t = t >> SAMPLE_W;
    return t[F-1:0];
  endfunction

  // clamp above one, else round(v*255)
  function automatic logic [PIXEL_W-1:0] to_byte(input logic [F+1:0] v);
    logic [F:0]   vc;
    logic [F+8:0] m;
    vc = v[F:0];
    m  = {vc, 8'b0} - {8'b0, vc} + HALF9;
    if (v > {1'b0, ONE}) begin
      return 8'hFF;
    end
    return m[F+7:F];
  endfunction

  // configuration
  logic                mode;
  logic [SAMPLE_W-1:0] term_level;
  logic [SAMPLE_W-1:0] min_opa;

  // captured word
  logic [SAMPLE_W-1:0] in_red, in_green, in_blue, in_opa;
  logic                in_valid, in_last;

  // accumulators
  logic [F+1:0] acc_red, acc_green, acc_blue;
  logic [F:0]   acc_opa;

  logic [F-1:0] w_q;
  logic         contrib;

  // weight stage
  logic [F:0]   rem;
  logic [2*F:0] wprod;
  logic [2*F:0] wsum;
  logic         contrib_next;

  always_comb begin
    rem   = (acc_opa >= ONE) ? '0 : ONE - acc_opa;
    wprod = {{(F+1){1'b0}}, to_fx(in_opa)} * {{F{1'b0}}, rem};
    wsum  = wprod + HALF;
    contrib_next = in_valid && (in_opa >= min_opa)
                   && (acc_opa <= {1'b0, to_fx(term_level)});
  end

  // colour stage, three lanes
  logic [2*F:0] csum_r, csum_g, csum_b;
  logic [F+2:0] s_r, s_g, s_b;
  logic [F+1:0] s_o;

  always_comb begin
    csum_r = {{(F+1){1'b0}}, to_fx(in_red)}   * {{(F+1){1'b0}}, w_q} + HALF;
    csum_g = {{(F+1){1'b0}}, to_fx(in_green)} * {{(F+1){1'b0}}, w_q} + HALF;
    csum_b = {{(F+1){1'b0}}, to_fx(in_blue)}  * {{(F+1){1'b0}}, w_q} + HALF;
    s_r = {1'b0, acc_red}   + {2'b00, csum_r[2*F:F]};
    s_g = {1'b0, acc_green} + {2'b00, csum_g[2*F:F]};
    s_b = {1'b0, acc_blue}  + {2'b00, csum_b[2*F:F]};
    s_o = {1'b0, acc_opa}   + {2'b00, w_q};
  end

  assign sts.last     = in_last;
  assign sts.out_free = !m_tvalid || m_tready;

  // control state, accumulators and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      term_level <= TERM_LEVEL_RESET;
      min_opa    <= MIN_OPA_RESET;
      acc_red    <= '0;
      acc_green  <= '0;
      acc_blue   <= '0;
      acc_opa    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA_ONLY: mode       <= cfg_data[0];
          REG_TERM_LEVEL: term_level <= cfg_data[SAMPLE_W-1:0];
          REG_MIN_OPA:    min_opa    <= cfg_data[SAMPLE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.acc_upd && contrib) begin
        if (!mode) begin
          acc_red   <= s_r[F+2] ? '1 : s_r[F+1:0];
          acc_green <= s_g[F+2] ? '1 : s_g[F+1:0];
          acc_blue  <= s_b[F+2] ? '1 : s_b[F+1:0];
        end
        acc_opa <= s_o[F+1] ? '1 : s_o[F:0];
      end
      if (cmd.emit) begin
        acc_red   <= '0;
        acc_green <= '0;
        acc_blue  <= '0;
        acc_opa   <= '0;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_red   <= s_tdata[SAMPLE_W-1:0];
      in_green <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      in_blue  <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      in_opa   <= s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
      in_valid <= s_tuser[0];
      in_last  <= s_tlast;
    end
    if (cmd.calc_w) begin
      w_q     <= wsum[2*F-1:F];
      contrib <= contrib_next;
    end
    if (cmd.emit) begin
      m_tdata <= {to_byte({1'b0, acc_opa}),
                  mode ? 8'h00 : to_byte(acc_blue),
                  mode ? 8'h00 : to_byte(acc_green),
                  mode ? 8'h00 : to_byte(acc_red)};
    end
  end

endmodule
`default_nettype wire

[rtl/front_to_back_ray_compositor.sv]
// top level of the front-to-back ray compositor
//
// usage: ray samples arrive on the s_ side, one word per sample; s_tuser[0] says a
// sample is present, s_tlast marks the last word of a ray. every valid sample whose
// opacity reaches min_sample_opacity, while accumulated opacity is not above
// termination_level, is blended front to back into q2.FRAC_BITS colour and q1.FRAC_BITS
// opacity accumulators. on the last word one rgba8 pixel leaves on the m_ side and
// the accumulators clear. each word passes through capture, weight multiply, and
// colour multiply and accumulate; the weight and colour multiplies are a dependent
// loop, and the next word is taken only after the last is accumulated. a ray-ending
// word adds an emit step that loads its pixel. s_tready is high only while the
// controller waits for a word. a pixel waits in the output register while m_tready
// is low; the next ray is still taken, but its emit step holds till the register frees.
// reset (rst, synchronous) clears accumulators, output valid and configuration to
// rgba mode, termination 0.97 and minimum opacity one lsb. configuration writes
// on cfg_we take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none
module front_to_back_ray_compositor #(
  parameter int FRAC_BITS = 16     // accumulator fraction bits, 8 to 24
) (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration write port
  input  wire                                  cfg_we,
  input  wire [ftbrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ftbrc_pkg::CFG_W-1:0]           cfg_data,
  // sample words
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire [4*ftbrc_pkg::SAMPLE_W-1:0]      s_tdata,  // sample_red, sample_green, sample_blue, sample_opacity
  input  wire [0:0]                            s_tuser,  // sample_valid
  input  wire                                  s_tlast,  // ray_end
  // pixel words
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [4*ftbrc_pkg::PIXEL_W-1:0]      m_tdata   // pixel_red, pixel_green, pixel_blue, pixel_alpha
);
  import ftbrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: capture, weight, accumulate, emit
  ftbrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // multipliers, accumulators and the output register
  ftbrc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

[rtl/ftbrc_checker.sv]
// port-level checker of the ray compositor and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "front_to_back_ray_compositor_assert.svh"
module ftbrc_checker (
  input wire                                 clk,
  input wire                                 rst,
  input wire                                 s_tvalid,
  input wire                                 s_tready,
  input wire                                 m_tvalid,
  input wire                                 m_tready,
  input wire [4*ftbrc_pkg::PIXEL_W-1:0]      m_tdata
);

  // a stalled pixel holds
  `FTBRC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "pixel changed while stalled")

  // one word at a time: ready drops after a word is taken
  `FTBRC_ASSERT_NEXT(a_one_word, clk, rst, s_tvalid && s_tready, !s_tready, "second word taken before the first finished")

  // a new pixel only comes out of the emit step, never while waiting for input
  `FTBRC_ASSERT_SAME(a_emit_busy, clk, rst, $rose(m_tvalid), !$past(s_tready), "pixel appeared while idle")

  // reset leaves no pixel pending and the input open
  `FTBRC_ASSERT_SAME(a_reset_state, clk, rst, $past(rst), !m_tvalid && s_tready, "bad state after reset")

endmodule

bind front_to_back_ray_compositor ftbrc_checker u_ftbrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

[test/ray_pixel_checker.sv]
// pixel checker for the ray compositor: blends accepted sample words and compares pixel words
`timescale 1ns / 1ps
module ray_pixel_checker
  import ftbrc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire [CFG_IDX_W-1:0]      cfg_index,
  input  wire [CFG_W-1:0]          cfg_data,
  input  wire                      s_tvalid,
  input  wire                      s_tready,
  input  wire [4*SAMPLE_W-1:0]     s_tdata,   // sample_red, sample_green, sample_blue, sample_opacity
  input  wire [0:0]                s_tuser,   // sample_valid
  input  wire                      s_tlast,   // ray_end
  input  wire                      m_tvalid,
  input  wire                      m_tready,
  input  wire [4*PIXEL_W-1:0]      m_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha
  output int                       fail_count,
  output int                       pending
);

  localparam int COL_W = FRAC_BITS + 2;
  localparam int OPA_W = FRAC_BITS + 1;
  localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF    = ONE >> 1;
  localparam logic [63:0] COL_MAX = (64'd1 << COL_W) - 64'd1;
  localparam logic [63:0] OPA_MAX = (64'd1 << OPA_W) - 64'd1;

  // lowest field in the lowest bits, as on m_tdata
  typedef struct packed {
    logic [PIXEL_W-1:0] alpha;
    logic [PIXEL_W-1:0] blue;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] red;
  } pixel_t;

  logic                alpha_only;
  logic [SAMPLE_W-1:0] term_level;
  logic [SAMPLE_W-1:0] min_opacity;
  logic [COL_W-1:0]    acc_red;
  logic [COL_W-1:0]    acc_green;
  logic [COL_W-1:0]    acc_blue;
  logic [OPA_W-1:0]    acc_opacity;
  pixel_t              pixel_queue[$];
  pixel_t              got_pixel;
  pixel_t              want_pixel;
  string               label;

  function automatic logic [63:0] q16_to_fx(input logic [SAMPLE_W-1:0] v);
    if (FRAC_BITS >= 16) return {48'd0, v} << (FRAC_BITS - 16);
    return {48'd0, v} >> (16 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic logic [63:0] colour_term(input logic [SAMPLE_W-1:0] c,
                                              input logic [63:0] weight);
    return (q16_to_fx(c) * weight + HALF) >> FRAC_BITS;
  endfunction

  function automatic logic [PIXEL_W-1:0] to_pixel_byte(input logic [63:0] v);
    logic [63:0] scaled;
    if (v > ONE) return 8'hFF;
    scaled = (v * 64'd255 + HALF) >> FRAC_BITS;
    return scaled[PIXEL_W-1:0];
  endfunction

  // blend one accepted word and queue the pixel it closes, if any
  task automatic composite_word(input logic [4*SAMPLE_W-1:0] data, input logic present,
                                input logic ends);
    logic [SAMPLE_W-1:0] opa;
    logic [63:0]         remain;
    logic [63:0]         weight;
    pixel_t              px;
    opa = data[3*SAMPLE_W +: SAMPLE_W];
    if (present && opa >= min_opacity && 64'(acc_opacity) <= q16_to_fx(term_level)) begin
      remain = (64'(acc_opacity) >= ONE) ? 64'd0 : ONE - 64'(acc_opacity);
      weight = (q16_to_fx(opa) * remain + HALF) >> FRAC_BITS;
      if (!alpha_only) begin
        acc_red   = COL_W'(add_sat(64'(acc_red),
                                   colour_term(data[0 +: SAMPLE_W], weight), COL_MAX));
        acc_green = COL_W'(add_sat(64'(acc_green),
                                   colour_term(data[SAMPLE_W +: SAMPLE_W], weight), COL_MAX));
        acc_blue  = COL_W'(add_sat(64'(acc_blue),
                                   colour_term(data[2*SAMPLE_W +: SAMPLE_W], weight), COL_MAX));
      end
      acc_opacity = OPA_W'(add_sat(64'(acc_opacity), weight, OPA_MAX));
    end
    if (ends) begin
      px.red   = alpha_only ? '0 : to_pixel_byte(64'(acc_red));
      px.green = alpha_only ? '0 : to_pixel_byte(64'(acc_green));
      px.blue  = alpha_only ? '0 : to_pixel_byte(64'(acc_blue));
      px.alpha = to_pixel_byte(64'(acc_opacity));
      pixel_queue.push_back(px);
      acc_red     = '0;
      acc_green   = '0;
      acc_blue    = '0;
      acc_opacity = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      alpha_only  = 1'b0;
      term_level  = TERM_LEVEL_RESET;
      min_opacity = MIN_OPA_RESET;
      acc_red     = '0;
      acc_green   = '0;
      acc_blue    = '0;
      acc_opacity = '0;
      pixel_queue.delete();
      fail_count  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_pixel = pixel_t'(m_tdata);
        if (pixel_queue.size() == 0) begin
          $error("pixel word with no pixel expected: %h", m_tdata);
          fail_count++;
        end else begin
          want_pixel = pixel_queue.pop_front();
          for (int f = 0; f < 4; f++) begin
            case (f)
              0: label = "pixel_red";
              1: label = "pixel_green";
              2: label = "pixel_blue";
              default: label = "pixel_alpha";
            endcase
            if (got_pixel[PIXEL_W*f +: PIXEL_W] !== want_pixel[PIXEL_W*f +: PIXEL_W]) begin
              $error("%s mismatch: expected %0d, actual %0d", label,
                     want_pixel[PIXEL_W*f +: PIXEL_W], got_pixel[PIXEL_W*f +: PIXEL_W]);
              fail_count++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) composite_word(s_tdata, s_tuser[0], s_tlast);
      // register writes count from the next word on
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHA_ONLY: alpha_only  = cfg_data[0];
          REG_TERM_LEVEL: term_level  = cfg_data[SAMPLE_W-1:0];
          REG_MIN_OPA:    min_opacity = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = pixel_queue.size();
  end

endmodule

[test/tb_top.sv]
// testbench top for the front-to-back ray compositor: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_top;
  import ftbrc_pkg::*;

  localparam int FRAC_BITS        = 16;
  localparam int CYCLE_LIMIT      = 200000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES    = 16;      // covers a word's capture, weight, accumulate and emit steps with margin
  localparam int SINK_HOLD_CYCLES = 300;     // long enough to back the block up
  localparam int PHASE_COUNT      = 8;
  localparam int PHASE_ITEMS      = 175;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register behind this index
  localparam logic [SAMPLE_W-1:0]  Q16_MAX    = 16'hFFFF;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  wire                    s_tready;
  logic [4*SAMPLE_W-1:0]  s_tdata;   // sample_red, sample_green, sample_blue, sample_opacity
  logic [0:0]             s_tuser;   // sample_valid
  logic                   s_tlast;   // ray_end
  wire                    m_tvalid;
  logic                   m_tready;
  wire  [4*PIXEL_W-1:0]   m_tdata;   // pixel_red, pixel_green, pixel_blue, pixel_alpha

  int   fail_count;
  int   pending;
  int   src_idle_pct;
  int   sink_stall_pct;
  logic sink_hold_req;
  int   items_sent;
  int   cur_min_opa;
  int   cycle_count = 0;

  front_to_back_ray_compositor #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // watches both streams and the register port, owns all pixel checks
  ray_pixel_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_pixel_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // pixel side: random stalls, plus one long hold-off on request
  initial begin
    m_tready      <= 1'b0;
    sink_hold_req <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_tready      <= 1'b0;
        sink_hold_req <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // colours lean toward the rails now and then
  function automatic logic [SAMPLE_W-1:0] pick_colour();
    case ($urandom_range(9))
      0: return '0;
      1: return Q16_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // opacity mix: anywhere, faint, nearly opaque, or at or beside the skip threshold
  function automatic logic [SAMPLE_W-1:0] pick_opacity();
    int near;
    case ($urandom_range(3))
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(511));
      2: return SAMPLE_W'($urandom_range(16'hF000, 16'hFFFF));
      default: begin
        near = cur_min_opa + int'($urandom_range(2)) - 1;
        if (near < 0) near = 0;
        if (near > 65535) near = 65535;
        return SAMPLE_W'(near);
      end
    endcase
  endfunction

  // offer one sample word and hold it until taken; tvalid stays up for the next word
  task automatic send_word(input logic [SAMPLE_W-1:0] red, input logic [SAMPLE_W-1:0] green,
                           input logic [SAMPLE_W-1:0] blue, input logic [SAMPLE_W-1:0] opa,
                           input logic present, input logic ends);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {opa, blue, green, red};
    s_tuser  <= present;
    s_tlast  <= ends;
    do @(posedge clk); while (!s_tready);
    // words without a sample and without an end are ignored by the block
    if (present || ends) items_sent++;
  endtask

  // stop offering, let every pixel come back and the datapath go quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic mode, input logic [SAMPLE_W-1:0] level,
                                input logic [SAMPLE_W-1:0] min_opa);
    write_reg(REG_ALPHA_ONLY, {{(CFG_W-1){1'b0}}, mode});
    write_reg(REG_TERM_LEVEL, level);
    write_reg(REG_MIN_OPA, min_opa);
    cfg_we      <= 1'b0;
    cur_min_opa = min_opa;
  endtask

  // one ray: some samples with random noise words mixed in, closed either on the
  // last sample or by a separate end-only word
  task automatic send_ray();
    int   samples;
    logic closes_on_sample;
    samples          = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 8);
    closes_on_sample = (samples > 0) && ($urandom_range(99) < 60);
    for (int k = 0; k < samples; k++) begin
      if ($urandom_range(9) == 0)
        send_word(pick_colour(), pick_colour(), pick_colour(), pick_opacity(), 1'b0, 1'b0);
      send_word(pick_colour(), pick_colour(), pick_colour(), pick_opacity(), 1'b1,
                closes_on_sample && (k == samples - 1));
    end
    if (!closes_on_sample)
      send_word(pick_colour(), pick_colour(), pick_colour(), pick_opacity(), 1'b0, 1'b1);
  endtask

  initial begin
    int phase_start;
    bit hold_done;
    bit pause_done;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= '0;
    s_tlast        <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    cur_min_opa    = MIN_OPA_RESET;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed rays on reset settings
    // empty ray: the sample bits are ignored when no sample is flagged
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, 1'b0, 1'b1);
    // stray word with neither sample nor end
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, 1'b0, 1'b0);
    // full white fully opaque sample closing its own ray
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, 1'b1, 1'b1);
    // opacity under the minimum, skipped
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, 16'd0, 1'b1, 1'b1);
    // opacity exactly at the minimum still counts
    send_word(Q16_MAX, 16'd0, Q16_MAX, 16'd1, 1'b1, 1'b1);
    // build past the termination level, then a sample that must be ignored
    send_word(Q16_MAX, 16'd0, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_word(16'd0, Q16_MAX, 16'd0, Q16_MAX, 1'b1, 1'b0);
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, 1'b1, 1'b0);
    send_word(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    // checkerboard bit patterns
    send_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0);
    send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b1);
    // switch to opacity-only in the middle of a ray: earlier colour is dropped
    send_word(Q16_MAX, 16'h8000, 16'd0, 16'h4000, 1'b1, 1'b0);
    send_word(16'h1234, Q16_MAX, 16'hABCD, 16'h2000, 1'b1, 1'b0);
    wait_drained();
    write_reg(REG_ALPHA_ONLY, 16'd1);
    cfg_we <= 1'b0;
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, 16'h8000, 1'b1, 1'b1);
    // write to a missing index is dropped, the mode bit ignores upper data bits
    wait_drained();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_ALPHA_ONLY, 16'hFFFE);
    cfg_we <= 1'b0;
    send_word(16'hC000, 16'h4000, Q16_MAX, 16'hC000, 1'b1, 1'b0);
    send_word(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, 1'b1, 1'b1);

    // random rays, one register setting and flow-control mix per phase
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(1'b0, TERM_LEVEL_RESET, MIN_OPA_RESET);
        1: apply_settings(1'b0, Q16_MAX, 16'd0);
        2: apply_settings(1'b1, 16'd0, 16'd0);
        3: apply_settings(1'b0, 16'h8000, 16'd1000);
        4: apply_settings(1'b1, Q16_MAX, Q16_MAX);
        5: apply_settings(1'b0, SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(2000)));
        6: apply_settings(1'b0, 16'd0, Q16_MAX);
        default: apply_settings(1'b1, SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(600)));
      endcase
      src_idle_pct   = (phase % 4 == 1) ? 69 : (phase % 4 == 3) ? 23 : 0;
      sink_stall_pct = (phase % 4 == 2) ? 69 : (phase % 4 == 3) ? 23 : 0;
      phase_start    = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_ray();
        // pixel side goes dark while words keep coming, so the input backs up
        if (phase == 0 && !hold_done && items_sent - phase_start >= 40) begin
          sink_hold_req <= 1'b1;
          hold_done = 1'b1;
        end
        // sender pause until every pixel is back
        if (phase == 3 && !pause_done && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_drained();
          pause_done = 1'b1;
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ftbrc_pkg.sv
rtl/ftbrc_ctrl.sv
rtl/ftbrc_dp.sv
rtl/front_to_back_ray_compositor.sv
rtl/ftbrc_checker.sv
test/ray_pixel_checker.sv
test/tb_top.sv
